>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that also holds while reset is held.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/slru_pkg.sv
// Shared constants, codes and word types of the LRU replacement block.
package slru_pkg;

    // Geometry; SETS and WAYS are powers of two
    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int OFFSET_BITS = 6;
    localparam int ADDR_BITS   = 32;

    localparam int SET_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int LINE_BITS = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_BITS  = LINE_BITS - SET_BITS;

    // Port field widths
    localparam int OPC_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int FLAG_W   = 2;
    localparam int STATUS_W = 2;
    localparam int WAYOUT_W = 2;

    // Queue depth between the stages (power of two)
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Opcodes
    localparam logic [OPC_W-1:0] OP_TOUCH = 2'd0;
    localparam logic [OPC_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OPC_W-1:0] OP_EVICT = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [ADDR_W-1:0] address;
        logic [FLAG_W-1:0] block_flag;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   victim_address;
        logic [FLAG_W-1:0]   victim_flag;
        logic [WAYOUT_W-1:0] way_used;
    } t_out_word;

    // Decoded request held between front and back
    typedef struct packed {
        logic [OPC_W-1:0]    opcode;
        logic [SET_BITS-1:0] set;
        logic [TAG_BITS-1:0] tag;
        logic [FLAG_W-1:0]   flag;
    } t_req;

    // Request queue head as seen by the back end
    typedef struct packed {
        logic empty;
        t_req req;
    } t_req_q;

    // Result handed to the result queue
    typedef struct packed {
        logic      push;
        t_out_word word;
    } t_res_push;

    // One way of a tag row, and a whole set
    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [FLAG_W-1:0]   flag;
        logic [WAY_BITS-1:0] age;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

endpackage

>>> rtl/slru_front.sv
// Front end: accepts request words, splits the address and queues them.
module slru_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  slru_pkg::t_in_word i_word,
    input  logic              i_pop,
    output slru_pkg::t_req_q  o_req_q
);

    slru_pkg::t_req                    r_q [slru_pkg::Q_DEPTH];
    logic [slru_pkg::Q_PTR_BITS-1:0]   r_wptr;
    logic [slru_pkg::Q_PTR_BITS-1:0]   r_rptr;
    logic [slru_pkg::Q_CNT_BITS-1:0]   r_cnt;
    logic [slru_pkg::ADDR_BITS-1:0]    addr;
    slru_pkg::t_req                    dec;
    logic                              do_push;
    logic                              do_pop;

    // Split the byte address into set index and tag
    always_comb begin
        addr       = i_word.address[slru_pkg::ADDR_BITS-1:0];
        dec.opcode = i_word.opcode;
        dec.set    = addr[slru_pkg::OFFSET_BITS +: slru_pkg::SET_BITS];
        dec.tag    = addr[slru_pkg::OFFSET_BITS + slru_pkg::SET_BITS +: slru_pkg::TAG_BITS];
        dec.flag   = i_word.block_flag;
    end

    assign full          = (r_cnt == slru_pkg::Q_CNT_BITS'(slru_pkg::Q_DEPTH));
    assign do_push       = push && !full;
    assign do_pop        = i_pop && (r_cnt != '0);
    assign o_req_q.empty = (r_cnt == '0);
    assign o_req_q.req   = r_q[r_rptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + slru_pkg::Q_CNT_BITS'(do_push) - slru_pkg::Q_CNT_BITS'(do_pop);
        end
    end

    // Store the decoded word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= dec;
        end
    end

endmodule

>>> rtl/slru_back.sv
// Back end: per-set read-modify-write of tags, flags, valid bits and ages.
module slru_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slru_pkg::t_req_q    i_req_q,
    output logic                o_req_pop,
    input  logic                i_res_full,
    output slru_pkg::t_res_push o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUSH
    } t_state;

    t_state                  r_state;
    slru_pkg::t_req          r_req;
    slru_pkg::t_row          r_row;
    logic [slru_pkg::WAYS-1:0] r_vrow;
    slru_pkg::t_out_word     r_res;
    logic [slru_pkg::WAYS-1:0] r_valid [slru_pkg::SETS];
    slru_pkg::t_row          r_mem [slru_pkg::SETS];

    logic [slru_pkg::WAYS-1:0] cur_v;
    logic [slru_pkg::WAYS-1:0] n_vrow;
    slru_pkg::t_row          n_row;
    slru_pkg::t_out_word     n_res;
    logic                    hit_found;
    logic [slru_pkg::WAY_BITS-1:0] hit_way;
    logic                    free_found;
    logic [slru_pkg::WAY_BITS-1:0] free_way;
    logic                    old_found;
    logic [slru_pkg::WAY_BITS-1:0] old_way;
    logic [slru_pkg::WAY_BITS-1:0] hit_age;
    logic [slru_pkg::ADDR_BITS-1:0] rebuilt;

    assign o_req_pop  = (r_state == S_IDLE) && !i_req_q.empty;
    assign o_res.push = (r_state == S_PUSH) && !i_res_full;
    assign o_res.word = r_res;
    assign cur_v      = r_vrow;

    // Search the set: lowest matching way, lowest free way, oldest valid way
    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        old_found  = 1'b0;
        old_way    = '0;
        for (int w = slru_pkg::WAYS - 1; w >= 0; w--) begin
            if (cur_v[w] && (r_row[w].tag == r_req.tag)) begin
                hit_found = 1'b1;
                hit_way   = slru_pkg::WAY_BITS'(w);
            end
            if (!cur_v[w]) begin
                free_found = 1'b1;
                free_way   = slru_pkg::WAY_BITS'(w);
            end
        end
        for (int w = 0; w < slru_pkg::WAYS; w++) begin
            if (cur_v[w] && (!old_found || (r_row[w].age > r_row[old_way].age))) begin
                old_found = 1'b1;
                old_way   = slru_pkg::WAY_BITS'(w);
            end
        end
        hit_age = r_row[hit_way].age;
        rebuilt = {r_row[old_way].tag, r_req.set, {slru_pkg::OFFSET_BITS{1'b0}}};
    end

    // Build the updated row and the result word
    always_comb begin
        n_row = r_row;
        n_vrow = cur_v;
        n_res = '0;
        n_res.status = slru_pkg::ST_MISS;
        case (r_req.opcode)
            slru_pkg::OP_TOUCH: begin
                if (hit_found) begin
                    for (int w = 0; w < slru_pkg::WAYS; w++) begin
                        if (cur_v[w] && (r_row[w].age < hit_age)) begin
                            n_row[w].age = r_row[w].age + 1'b1;
                        end
                    end
                    n_row[hit_way].age  = '0;
                    n_row[hit_way].flag = r_req.flag;
                    n_res.status   = slru_pkg::ST_DONE;
                    n_res.way_used = slru_pkg::WAYOUT_W'(hit_way);
                end
            end
            slru_pkg::OP_FILL: begin
                if (free_found) begin
                    for (int w = 0; w < slru_pkg::WAYS; w++) begin
                        if (cur_v[w]) begin
                            n_row[w].age = r_row[w].age + 1'b1;
                        end
                    end
                    n_row[free_way].tag  = r_req.tag;
                    n_row[free_way].flag = r_req.flag;
                    n_row[free_way].age  = '0;
                    n_vrow[free_way]     = 1'b1;
                    n_res.status   = slru_pkg::ST_DONE;
                    n_res.way_used = slru_pkg::WAYOUT_W'(free_way);
                end else begin
                    n_res.status = slru_pkg::ST_FULL;
                end
            end
            slru_pkg::OP_EVICT: begin
                if (old_found) begin
                    n_row[old_way].age = '0;
                    n_vrow[old_way]    = 1'b0;
                    n_res.status         = slru_pkg::ST_DONE;
                    n_res.victim_address = slru_pkg::ADDR_W'(rebuilt);
                    n_res.victim_flag    = r_row[old_way].flag;
                    n_res.way_used       = slru_pkg::WAYOUT_W'(old_way);
                end
            end
            default: begin
                n_res.status = slru_pkg::ST_MISS;
            end
        endcase
    end

    // Sequence one word: fetch row, update, hand result over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int s = 0; s < slru_pkg::SETS; s++) begin
                r_valid[s] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_req_pop) begin
                        r_req   <= i_req_q.req;
                        r_vrow  <= r_valid[i_req_q.req.set];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_valid[r_req.set] <= n_vrow;
                    r_res   <= n_res;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Tag row memory: read on fetch, write back on update
    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_row <= r_mem[i_req_q.req.set];
        end
        if (r_state == S_EXEC) begin
            r_mem[r_req.set] <= n_row;
        end
    end

endmodule

>>> rtl/slru_resq.sv
// Result queue: holds finished result words until they are popped.
module slru_resq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slru_pkg::t_res_push i_res,
    output logic                o_full,
    input  logic                pop,
    output logic                empty,
    output slru_pkg::t_out_word o_word
);

    slru_pkg::t_out_word             r_q [slru_pkg::Q_DEPTH];
    logic [slru_pkg::Q_PTR_BITS-1:0] r_wptr;
    logic [slru_pkg::Q_PTR_BITS-1:0] r_rptr;
    logic [slru_pkg::Q_CNT_BITS-1:0] r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_cnt == slru_pkg::Q_CNT_BITS'(slru_pkg::Q_DEPTH));
    assign empty   = (r_cnt == '0);
    assign do_push = i_res.push && !o_full;
    assign do_pop  = pop && !empty;
    assign o_word  = r_q[r_rptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + slru_pkg::Q_CNT_BITS'(do_push) - slru_pkg::Q_CNT_BITS'(do_pop);
        end
    end

    // Store the result word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= i_res.word;
        end
    end

endmodule

>>> rtl/set_assoc_lru_replacement.sv
// A request word is queued by the front end, then handled by the back end's row
// sequencer (row read, update and write-back, hand-off to the result queue), which
// takes no new word until it has handed the last result to the result queue.
// Two-word queues on each side let input and output stall independently.
// Reset is synchronous, active low: valid bits, queues and sequencer clear at
// once, with no clearing pass; tag and flag rows stay undefined until written.
module set_assoc_lru_replacement (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  slru_pkg::t_in_word  i_word,
    output logic                empty,
    input  logic                pop,
    output slru_pkg::t_out_word o_word
);

    slru_pkg::t_req_q    req_q;
    logic                req_pop;
    slru_pkg::t_res_push res;
    logic                res_full;

    // Accept and decode request words
    slru_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .i_pop   (req_pop),
        .o_req_q (req_q)
    );

    // Update the set state
    slru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_q    (req_q),
        .o_req_pop  (req_pop),
        .i_res_full (res_full),
        .o_res      (res)
    );

    // Hold result words
    slru_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (res_full),
        .pop     (pop),
        .empty   (empty),
        .o_word  (o_word)
    );

endmodule

>>> rtl/slru_checker.sv
// Port-level checks of the replacement block and their bind to the top level.
`include "assert_macros.svh"

module slru_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input slru_pkg::t_out_word o_word
);

    logic st_known;
    logic no_victim;

    // Classify the word on the result ports
    assign st_known  = (o_word.status == slru_pkg::ST_DONE) ||
                       (o_word.status == slru_pkg::ST_MISS) ||
                       (o_word.status == slru_pkg::ST_FULL);
    assign no_victim = (o_word.victim_address == '0) && (o_word.victim_flag == '0) &&
                       (o_word.way_used == '0);

    // A waiting result word holds until popped
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_word)))

    // Reset leaves no result waiting
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty)

    // Status is one of the defined codes
    `ASSERT_CLK(a_status, i_clk, i_rst_n, !empty |-> st_known)

    // A request that ends in a miss carries no victim and no way
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, (!empty && !o_word.status[1] && o_word.status[0]) |-> no_victim)

endmodule

bind set_assoc_lru_replacement slru_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_word  (o_word)
);

>>> dv/testbench.sv
// Self-checking testbench for the true-LRU replacement block of the set-associative tag store.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRY_COUNT = slru_pkg::SETS * slru_pkg::WAYS;

    // Opcode that the block does not define
    localparam logic [slru_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push    = 1'b0;
    logic                pop     = 1'b0;
    slru_pkg::t_in_word  i_word  = '0;
    logic                full;
    logic                empty;
    slru_pkg::t_out_word o_word;

    // Shadow of the replacement state, one entry per set and way
    logic [slru_pkg::TAG_BITS-1:0] shadow_tag   [ENTRY_COUNT];
    logic                          shadow_valid [ENTRY_COUNT];
    logic [slru_pkg::FLAG_W-1:0]   shadow_flag  [ENTRY_COUNT];
    logic [slru_pkg::WAY_BITS-1:0] shadow_age   [ENTRY_COUNT];

    slru_pkg::t_out_word           pending_outcomes[$];
    int                            mismatch_count = 0;
    bit                            idle_on        = 1'b1;
    int                            hold_request   = 0;
    logic [slru_pkg::TAG_BITS-1:0] tag_pool[8];

    set_assoc_lru_replacement i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word)
    );

    always #5 i_clk = ~i_clk;

    // Build a byte address from tag, set index and byte offset
    function automatic logic [slru_pkg::ADDR_W-1:0] make_addr(
        input logic [slru_pkg::TAG_BITS-1:0]    tag,
        input logic [slru_pkg::SET_BITS-1:0]    set_idx,
        input logic [slru_pkg::OFFSET_BITS-1:0] offs);
        return {tag, set_idx, offs};
    endfunction

    // Apply one request word to the shadow state and return the outcome word
    function automatic slru_pkg::t_out_word lru_predict(input slru_pkg::t_in_word w);
        slru_pkg::t_out_word           r;
        logic [slru_pkg::SET_BITS-1:0] set_idx;
        logic [slru_pkg::TAG_BITS-1:0] tag;
        logic [slru_pkg::WAY_BITS-1:0] rank;
        logic [slru_pkg::ADDR_W-1:0]   rebuilt;
        int                            base;
        int                            pick;
        r        = '0;
        r.status = slru_pkg::ST_MISS;
        pick     = -1;
        set_idx  = w.address[slru_pkg::OFFSET_BITS +: slru_pkg::SET_BITS];
        tag      = w.address[slru_pkg::OFFSET_BITS+slru_pkg::SET_BITS +: slru_pkg::TAG_BITS];
        base     = set_idx * slru_pkg::WAYS;
        case (w.opcode)
            slru_pkg::OP_TOUCH: begin
                // lowest matching valid way wins
                for (int k = 0; k < slru_pkg::WAYS; k++)
                    if (pick < 0 && shadow_valid[base+k] && shadow_tag[base+k] == tag)
                        pick = k;
                if (pick >= 0) begin
                    rank = shadow_age[base+pick];
                    for (int k = 0; k < slru_pkg::WAYS; k++)
                        if (shadow_valid[base+k] && shadow_age[base+k] < rank)
                            shadow_age[base+k]++;
                    shadow_age[base+pick]  = '0;
                    shadow_flag[base+pick] = w.block_flag;
                    r.status   = slru_pkg::ST_DONE;
                    r.way_used = slru_pkg::WAYOUT_W'(pick);
                end
            end
            slru_pkg::OP_FILL: begin
                // lowest free way takes the new tag as most recent
                for (int k = 0; k < slru_pkg::WAYS; k++)
                    if (pick < 0 && !shadow_valid[base+k])
                        pick = k;
                if (pick < 0) begin
                    r.status = slru_pkg::ST_FULL;
                end else begin
                    for (int k = 0; k < slru_pkg::WAYS; k++)
                        if (shadow_valid[base+k])
                            shadow_age[base+k]++;
                    shadow_valid[base+pick] = 1'b1;
                    shadow_tag[base+pick]   = tag;
                    shadow_flag[base+pick]  = w.block_flag;
                    shadow_age[base+pick]   = '0;
                    r.status   = slru_pkg::ST_DONE;
                    r.way_used = slru_pkg::WAYOUT_W'(pick);
                end
            end
            slru_pkg::OP_EVICT: begin
                // oldest valid way; ties keep the lowest way
                for (int k = 0; k < slru_pkg::WAYS; k++)
                    if (shadow_valid[base+k] &&
                        (pick < 0 || shadow_age[base+k] > shadow_age[base+pick]))
                        pick = k;
                if (pick >= 0) begin
                    rebuilt = make_addr(shadow_tag[base+pick], set_idx, '0);
                    r.victim_address = rebuilt;
                    r.victim_flag    = shadow_flag[base+pick];
                    shadow_valid[base+pick] = 1'b0;
                    shadow_age[base+pick]   = '0;
                    r.status   = slru_pkg::ST_DONE;
                    r.way_used = slru_pkg::WAYOUT_W'(pick);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Offer one word, wait until it is taken, then record its outcome
    task automatic send_word(input logic [slru_pkg::OPC_W-1:0]  opc,
                             input logic [slru_pkg::ADDR_W-1:0] addr,
                             input logic [slru_pkg::FLAG_W-1:0] flag);
        int                 gap;
        slru_pkg::t_in_word w;
        w.opcode     = opc;
        w.address    = addr;
        w.block_flag = flag;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (full);
        pending_outcomes.insert(pending_outcomes.size(), lru_predict(w));
    endtask

    // Drop push and wait until every outstanding word has come back
    task automatic drain_outcomes();
        push <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Compare one result word with the oldest outstanding outcome
    task automatic check_word(input slru_pkg::t_out_word got);
        slru_pkg::t_out_word want;
        if (pending_outcomes.size() == 0) begin
            $error("unexpected result word %h", got);
            mismatch_count++;
        end else begin
            want = pending_outcomes.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.victim_address !== want.victim_address) begin
                $error("victim_address: expected %h, got %h",
                       want.victim_address, got.victim_address);
                mismatch_count++;
            end
            if (got.victim_flag !== want.victim_flag) begin
                $error("victim_flag: expected %0d, got %0d", want.victim_flag, got.victim_flag);
                mismatch_count++;
            end
            if (got.way_used !== want.way_used) begin
                $error("way_used: expected %0d, got %0d", want.way_used, got.way_used);
                mismatch_count++;
            end
        end
    endtask

    // Empty set: evict and touch miss, unused opcode is rejected
    task automatic test_empty_set();
        send_word(slru_pkg::OP_EVICT, make_addr('0, 6'd0, '0), 2'd3);
        send_word(slru_pkg::OP_TOUCH, make_addr('0, 6'd0, '1), 2'd1);
        send_word(OP_UNUSED, 32'hFFFF_FFFF, 2'd3);
        drain_outcomes();
    endtask

    // Fill a set to the brim with extreme tags, then one fill too many
    task automatic test_fill_to_full();
        send_word(slru_pkg::OP_FILL, 32'hFFFF_FFFF, 2'd3);
        send_word(slru_pkg::OP_FILL, make_addr('0, 6'd63, '0), 2'd0);
        send_word(slru_pkg::OP_FILL, make_addr(20'h5A5A5, 6'd63, 6'h15), 2'd2);
        send_word(slru_pkg::OP_FILL, make_addr(20'hA5A5A, 6'd63, 6'h2A), 2'd1);
        send_word(slru_pkg::OP_FILL, make_addr(20'h12345, 6'd63, '0), 2'd2);
        drain_outcomes();
    endtask

    // Reorder by touches, miss on an absent tag, evict the set dry
    task automatic test_touch_and_evict();
        send_word(slru_pkg::OP_TOUCH, make_addr('1, 6'd63, 6'h07), 2'd0);
        send_word(slru_pkg::OP_TOUCH, make_addr(20'hA5A5A, 6'd63, '0), 2'd3);
        send_word(slru_pkg::OP_TOUCH, make_addr(20'h00001, 6'd63, '0), 2'd3);
        send_word(OP_UNUSED, make_addr('0, 6'd63, '0), 2'd0);
        repeat (5)
            send_word(slru_pkg::OP_EVICT,
                      make_addr(slru_pkg::TAG_BITS'($urandom), 6'd63,
                                slru_pkg::OFFSET_BITS'($urandom)), 2'd0);
        drain_outcomes();
    endtask

    // Same tag filled twice: touch acts on the lowest way
    task automatic test_duplicate_tag();
        send_word(slru_pkg::OP_FILL, make_addr(20'h0BEEF, 6'd10, '0), 2'd1);
        send_word(slru_pkg::OP_FILL, make_addr(20'h0BEEF, 6'd10, '0), 2'd2);
        send_word(slru_pkg::OP_TOUCH, make_addr(20'h0BEEF, 6'd10, '0), 2'd3);
        send_word(slru_pkg::OP_EVICT, make_addr('0, 6'd10, '0), 2'd0);
        send_word(slru_pkg::OP_EVICT, make_addr('0, 6'd10, '0), 2'd0);
        drain_outcomes();
    endtask

    // One random word; mostly a few busy sets so touches hit and sets fill
    task automatic random_item();
        logic [slru_pkg::SET_BITS-1:0] set_idx;
        logic [slru_pkg::TAG_BITS-1:0] tag;
        logic [slru_pkg::OPC_W-1:0]    opc;
        int                            sel;
        int                            live;
        int                            want_idx;
        set_idx = ($urandom_range(0, 9) < 7) ? slru_pkg::SET_BITS'($urandom_range(0, 3))
                                             : slru_pkg::SET_BITS'($urandom);
        tag     = ($urandom_range(0, 4) < 4) ? tag_pool[$urandom_range(0, 7)]
                                             : slru_pkg::TAG_BITS'($urandom);
        sel     = $urandom_range(0, 99);
        if (sel < 32)       opc = slru_pkg::OP_FILL;
        else if (sel < 72)  opc = slru_pkg::OP_TOUCH;
        else if (sel < 95)  opc = slru_pkg::OP_EVICT;
        else                opc = OP_UNUSED;
        // aim most touches at a block that is present
        if (opc == slru_pkg::OP_TOUCH && $urandom_range(0, 4) != 0) begin
            live = 0;
            for (int k = 0; k < slru_pkg::WAYS; k++)
                if (shadow_valid[set_idx*slru_pkg::WAYS+k]) live++;
            if (live > 0) begin
                want_idx = $urandom_range(0, live - 1);
                for (int k = 0; k < slru_pkg::WAYS; k++)
                    if (shadow_valid[set_idx*slru_pkg::WAYS+k]) begin
                        if (want_idx == 0) tag = shadow_tag[set_idx*slru_pkg::WAYS+k];
                        want_idx--;
                    end
            end
        end
        send_word(opc, make_addr(tag, set_idx, slru_pkg::OFFSET_BITS'($urandom)),
                  slru_pkg::FLAG_W'($urandom));
    endtask

    // Result side stalls long while the input keeps offering words
    task automatic test_backpressure();
        idle_on      = 1'b0;
        hold_request = 150;
        repeat (30) random_item();
        drain_outcomes();
        idle_on = 1'b1;
    endtask

    // Bulk random traffic, stretches with and without idling
    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 12; chunk++) begin
            idle_on = (chunk % 3) != 2;
            repeat (150) random_item();
            if (chunk == 5) drain_outcomes();
        end
        drain_outcomes();
    endtask

    // Result side: random stalls, an occasional long hold, check each word
    initial begin : result_checker
        int gap;
        @(posedge i_clk iff i_rst_n === 1'b1);
        forever begin
            if (hold_request > 0) begin
                gap          = hold_request;
                hold_request = 0;
            end else begin
                gap = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_word(o_word);
        end
    end

    // Main sequence
    initial begin : run_tests
        for (int k = 0; k < ENTRY_COUNT; k++) begin
            shadow_tag[k]   = '0;
            shadow_valid[k] = 1'b0;
            shadow_flag[k]  = '0;
            shadow_age[k]   = '0;
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < 8; k++) tag_pool[k] = slru_pkg::TAG_BITS'($urandom);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_set();
        test_fill_to_full();
        test_touch_and_evict();
        test_duplicate_tag();
        test_backpressure();
        test_random_traffic();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
